[src/ell_sparse_matrix_vector_multiply_unit_macros.svh]
// Assertion helpers for the ELL SpMV unit.
`ifndef ELL_SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_MACROS_SVH
`define ELL_SPARSE_MATRIX_VECTOR_MULTIPLY_UNIT_MACROS_SVH

// Clocked check, disabled while reset is held.
`define ELLSPMV_ASSERT(name, clock, reset_n, prop) \
  name: assert property (@(posedge clock) disable iff (!reset_n) prop) \
    else $error("ellspmv check failed");

// Clocked check that also runs through reset.
`define ELLSPMV_ASSERT_NR(name, clock, prop) \
  name: assert property (@(posedge clock) prop) \
    else $error("ellspmv check failed");

`endif

[src/ellspmv_pkg.sv]
`default_nettype none

package ellspmv_pkg;

  localparam int ACT_W     = 3;
  localparam int COL_W     = 8;
  localparam int VAL_W     = 16;
  localparam int CNT_W     = 9;
  localparam int ROW_IDX_W = 6;
  localparam int SUM_W     = 40;
  localparam int PROD_W    = 32;
  localparam int STAT_W    = 2;
  localparam int SLOT_W    = COL_W + VAL_W;

  localparam logic [CNT_W-1:0] COL_COUNT_RESET = 9'd256;

  localparam logic [ACT_W-1:0] ACT_APPEND    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_END_ROW   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_WRITE_VEC = 3'd2;
  localparam logic [ACT_W-1:0] ACT_MULTIPLY  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR     = 3'd4;

  localparam logic [STAT_W-1:0] STAT_SUM       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_SLOT_OVFL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_ROW_OVFL  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_EMPTY     = 2'd3;

endpackage

`default_nettype wire

[src/ell_sparse_matrix_vector_multiply_unit.sv]
// ELLPACK sparse matrix-vector multiply, Q8.8 operands, Q24.16 row sums.
// Input channel (in_valid / in_stall): one action per transfer. Append,
// end-row, vector write and clear can stream one per cycle while in_stall
// is low. A flag (slot overflow, row overflow, empty matrix) is one
// result item with last set, ready in the cycle after the transfer.
// Multiply walks the closed rows in order: per row a row-length read,
// then slot read, vector read, multiply and accumulate per entry
// through the one shared multiplier, then one result item; in_stall
// stays high until the last row sum is out.
// Result channel (out_valid / out_stall): one output register; while the
// receiver stalls, the result holds and the walk waits at its next emit.
// Configuration (cfg_valid / cfg_ready): col_count, always ready; write
// it only when the block is idle.
// Reset: no rows, empty open row, vector all zeros, col_count 256, no
// result pending. Matrix stores are not cleared.
`default_nettype none

module ell_sparse_matrix_vector_multiply_unit
  import ellspmv_pkg::*;
#(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_SLOTS = 16,
  parameter int MAX_COLS  = 256
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [ACT_W-1:0]            in_action,
  input  wire logic [COL_W-1:0]            in_entry_column,
  input  wire logic signed [VAL_W-1:0]     in_entry_value,
  input  wire logic [COL_W-1:0]            in_vector_index,
  input  wire logic signed [VAL_W-1:0]     in_vector_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [ROW_IDX_W-1:0]             out_row_index,
  output logic signed [SUM_W-1:0]          out_row_sum,
  output logic                             out_last,
  output logic [STAT_W-1:0]                out_status,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [CNT_W-1:0]            cfg_col_count
);

  localparam int RIW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RLW    = $clog2(MAX_ROWS + 1);
  localparam int SLW    = $clog2(MAX_SLOTS + 1);
  localparam int SDEPTH = MAX_ROWS * MAX_SLOTS;
  localparam int SAW    = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int VIW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_LEN, S_LEN_Q, S_SLOT, S_VEC, S_MUL, S_ACC, S_EMIT
  } state_t;

  state_t                    state_r;
  logic [RLW-1:0]            rows_loaded_r;
  logic [SLW-1:0]            cur_slot_r;
  logic [SLW-1:0]            longest_r;
  logic [CNT_W-1:0]          col_count_r;
  logic [MAX_COLS-1:0]       vec_vld_r;
  logic [RIW-1:0]            row_r;
  logic [SLW-1:0]            slot_r;
  logic [SLW-1:0]            len_r;
  logic signed [VAL_W-1:0]   val_r;
  logic                      in_range_r;
  logic                      vec_vld_q_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [SUM_W-1:0]   acc_r;

  logic                      out_valid_r;
  logic [ROW_IDX_W-1:0]      out_row_index_r;
  logic signed [SUM_W-1:0]   out_row_sum_r;
  logic                      out_last_r;
  logic [STAT_W-1:0]         out_status_r;

  logic                      in_fire;
  logic                      out_free;
  logic                      out_load;
  logic                      row_full;
  logic                      slot_full;
  logic                      row_last;

  logic                      slot_we;
  logic [SAW-1:0]            slot_waddr;
  logic [SAW-1:0]            slot_raddr;
  logic [SLOT_W-1:0]         slot_rdata;
  logic [COL_W-1:0]          slot_col;
  logic signed [VAL_W-1:0]   slot_val;

  logic                      len_we;
  logic [SLW-1:0]            len_rdata;

  logic                      vec_we;
  logic [VIW-1:0]            vec_waddr;
  logic [VIW-1:0]            vec_raddr;
  logic [VAL_W-1:0]          vec_rdata;
  logic signed [VAL_W-1:0]   vec_q;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  assign row_full  = rows_loaded_r >= RLW'(MAX_ROWS);
  assign slot_full = cur_slot_r >= SLW'(MAX_SLOTS);
  assign row_last  = (32'(row_r) + 32'd1) == 32'(rows_loaded_r);

  assign out_load = (in_fire &&
                     (((in_action == ACT_APPEND) && (row_full || slot_full)) ||
                      ((in_action == ACT_END_ROW) && row_full) ||
                      ((in_action == ACT_MULTIPLY) && (rows_loaded_r == '0)))) ||
                    ((state_r == S_EMIT) && out_free);

  assign slot_we    = in_fire && (in_action == ACT_APPEND) && !row_full && !slot_full;
  assign slot_waddr = SAW'(32'(rows_loaded_r) * MAX_SLOTS + 32'(cur_slot_r));
  assign slot_raddr = SAW'(32'(row_r) * MAX_SLOTS + 32'(slot_r));
  assign slot_col   = slot_rdata[VAL_W +: COL_W];
  assign slot_val   = signed'(slot_rdata[VAL_W-1:0]);

  assign len_we = in_fire && (in_action == ACT_END_ROW) && !row_full;

  assign vec_we    = in_fire && (in_action == ACT_WRITE_VEC) &&
                     (CNT_W'(in_vector_index) < CNT_W'(MAX_COLS));
  assign vec_waddr = VIW'(in_vector_index);
  assign vec_raddr = VIW'(slot_col);
  assign vec_q     = vec_vld_q_r ? signed'(vec_rdata) : '0;

  ellspmv_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SDEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata ({in_entry_column, in_entry_value}),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  ellspmv_ram #(
    .WIDTH (SLW),
    .DEPTH (MAX_ROWS)
  ) u_len_ram (
    .clk   (clk),
    .we    (len_we),
    .waddr (RIW'(rows_loaded_r)),
    .wdata (cur_slot_r),
    .raddr (row_r),
    .rdata (len_rdata)
  );

  ellspmv_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_COLS)
  ) u_vec_ram (
    .clk   (clk),
    .we    (vec_we),
    .waddr (vec_waddr),
    .wdata (in_vector_value),
    .raddr (vec_raddr),
    .rdata (vec_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      rows_loaded_r <= '0;
      cur_slot_r    <= '0;
      longest_r     <= '0;
      col_count_r   <= COL_COUNT_RESET;
      vec_vld_r     <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        col_count_r <= cfg_col_count;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (vec_we) begin
        vec_vld_r[vec_waddr] <= 1'b1;
      end

      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            case (in_action)
              ACT_APPEND: begin
                if (row_full || slot_full) begin
                  out_row_index_r <= ROW_IDX_W'(rows_loaded_r);
                  out_row_sum_r   <= '0;
                  out_last_r      <= 1'b1;
                  out_status_r    <= row_full ? STAT_ROW_OVFL : STAT_SLOT_OVFL;
                end else begin
                  cur_slot_r <= cur_slot_r + 1'b1;
                end
              end
              ACT_END_ROW: begin
                if (row_full) begin
                  out_row_index_r <= ROW_IDX_W'(rows_loaded_r);
                  out_row_sum_r   <= '0;
                  out_last_r      <= 1'b1;
                  out_status_r    <= STAT_ROW_OVFL;
                end else begin
                  if (cur_slot_r > longest_r) begin
                    longest_r <= cur_slot_r;
                  end
                  rows_loaded_r <= rows_loaded_r + 1'b1;
                  cur_slot_r    <= '0;
                end
              end
              ACT_MULTIPLY: begin
                if (rows_loaded_r == '0) begin
                  out_row_index_r <= '0;
                  out_row_sum_r   <= '0;
                  out_last_r      <= 1'b1;
                  out_status_r    <= STAT_EMPTY;
                end else begin
                  row_r   <= '0;
                  state_r <= S_LEN;
                end
              end
              ACT_CLEAR: begin
                rows_loaded_r <= '0;
                cur_slot_r    <= '0;
                longest_r     <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        S_LEN: begin
          state_r <= S_LEN_Q;
        end
        S_LEN_Q: begin
          len_r   <= len_rdata;
          slot_r  <= '0;
          acc_r   <= '0;
          state_r <= S_SLOT;
        end
        S_SLOT: begin
          if ((slot_r < len_r) && (slot_r < longest_r)) begin
            state_r <= S_VEC;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_VEC: begin
          val_r       <= slot_val;
          in_range_r  <= (CNT_W'(slot_col) < col_count_r) &&
                         (CNT_W'(slot_col) < CNT_W'(MAX_COLS));
          vec_vld_q_r <= vec_vld_r[vec_raddr];
          state_r     <= S_MUL;
        end
        S_MUL: begin
          prod_r  <= in_range_r ? (val_r * vec_q) : signed'(PROD_W'(0));
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r   <= acc_r + SUM_W'(prod_r);
          slot_r  <= slot_r + 1'b1;
          state_r <= S_SLOT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_row_index_r <= ROW_IDX_W'(row_r);
            out_row_sum_r   <= acc_r;
            out_last_r      <= row_last;
            out_status_r    <= STAT_SUM;
            if (row_last) begin
              state_r <= S_IDLE;
            end else begin
              row_r   <= row_r + 1'b1;
              state_r <= S_LEN;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_index_r;
  assign out_row_sum   = out_row_sum_r;
  assign out_last      = out_last_r;
  assign out_status    = out_status_r;

endmodule

`default_nettype wire

[src/ellspmv_ram.sv]
`default_nettype none

module ellspmv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[src/ellspmv_checker.sv]
`default_nettype none
`include "ell_sparse_matrix_vector_multiply_unit_macros.svh"

module ellspmv_checker
  import ellspmv_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [ROW_IDX_W-1:0]    out_row_index,
  input wire logic signed [SUM_W-1:0] out_row_sum,
  input wire logic                    out_last,
  input wire logic [STAT_W-1:0]       out_status
);

  `ELLSPMV_ASSERT_NR(a_reset_drops_result, clk, !rst_n |=> !out_valid)
  `ELLSPMV_ASSERT(a_stalled_result_holds, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_row_sum) && $stable(out_row_index) && $stable(out_status))
  `ELLSPMV_ASSERT(a_flag_is_final, clk, rst_n, out_valid && (out_status != STAT_SUM) |-> out_last && (out_row_sum == '0))
  `ELLSPMV_ASSERT(a_empty_row_zero, clk, rst_n, out_valid && (out_status == STAT_EMPTY) |-> out_row_index == '0)
  `ELLSPMV_ASSERT(a_run_blocks_input, clk, rst_n, out_valid && !out_last |-> in_stall)

endmodule

bind ell_sparse_matrix_vector_multiply_unit ellspmv_checker u_ellspmv_checker (.*);

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;
  import ellspmv_pkg::*;

  localparam int ROWS = 64;
  localparam int SLOTS = 16;
  localparam int COLS = 256;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [CNT_W-1:0] COL_SETTINGS [8] =
    '{9'd1, 9'd511, 9'd0, 9'd255, 9'd16, 9'd256, 9'd100, 9'd2};

  typedef struct {
    logic [ROW_IDX_W-1:0] row_index;
    logic [SUM_W-1:0]     row_sum;
    logic                 last;
    logic [STAT_W-1:0]    status;
  } row_result_t;

  class ell_product_scoreboard;
    logic [VAL_W-1:0] slot_value [ROWS*SLOTS];
    logic [COL_W-1:0] slot_col [ROWS*SLOTS];
    int unsigned      row_len [ROWS];
    logic [VAL_W-1:0] vec [COLS];
    int unsigned      rows_closed;
    int unsigned      open_len;
    int unsigned      col_count;
    row_result_t      expected_rows [$];
    int unsigned      mismatches;

    function new();
      foreach (vec[i]) vec[i] = '0;
      rows_closed = 0;
      open_len = 0;
      col_count = COL_COUNT_RESET;
      mismatches = 0;
    endfunction

    function void push(int unsigned row, logic [SUM_W-1:0] sum, logic last,
                       logic [STAT_W-1:0] status);
      row_result_t e;
      e.row_index = ROW_IDX_W'(row);
      e.row_sum = sum;
      e.last = last;
      e.status = status;
      expected_rows.push_back(e);
    endfunction

    function void note_transfer(logic [ACT_W-1:0] action, logic [COL_W-1:0] col,
                                logic [VAL_W-1:0] val, logic [COL_W-1:0] vidx,
                                logic [VAL_W-1:0] vval);
      int unsigned lim;
      int unsigned s;
      longint acc;
      case (action)
        ACT_APPEND: begin
          if (rows_closed >= ROWS) begin
            push(rows_closed, '0, 1'b1, STAT_ROW_OVFL);
          end else if (open_len >= SLOTS) begin
            push(rows_closed, '0, 1'b1, STAT_SLOT_OVFL);
          end else begin
            slot_col[rows_closed*SLOTS + open_len] = col;
            slot_value[rows_closed*SLOTS + open_len] = val;
            open_len++;
          end
        end
        ACT_END_ROW: begin
          if (rows_closed >= ROWS) begin
            push(rows_closed, '0, 1'b1, STAT_ROW_OVFL);
          end else begin
            row_len[rows_closed] = open_len;
            rows_closed++;
            open_len = 0;
          end
        end
        ACT_WRITE_VEC: vec[vidx] = vval;
        ACT_MULTIPLY: begin
          if (rows_closed == 0) begin
            push(0, '0, 1'b1, STAT_EMPTY);
          end else begin
            lim = (col_count < COLS) ? col_count : COLS;
            for (int unsigned r = 0; r < rows_closed; r++) begin
              acc = 0;
              for (int unsigned n = 0; n < row_len[r]; n++) begin
                s = r*SLOTS + n;
                if (slot_col[s] < lim)
                  acc += longint'($signed(slot_value[s])) *
                         longint'($signed(vec[slot_col[s]]));
              end
              push(r, acc[SUM_W-1:0], r + 1 == rows_closed, STAT_SUM);
            end
          end
        end
        ACT_CLEAR: begin
          rows_closed = 0;
          open_len = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(row_result_t got);
      row_result_t want;
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: row %0d sum %0d last %0b status %0d",
                   got.row_index, $signed(got.row_sum), got.last, got.status);
        return;
      end
      want = expected_rows.pop_front();
      if (got.row_index !== want.row_index || got.row_sum !== want.row_sum ||
          got.last !== want.last || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected row %0d sum %0d last %0b status %0d, got row %0d sum %0d last %0b status %0d",
                   want.row_index, $signed(want.row_sum), want.last, want.status,
                   got.row_index, $signed(got.row_sum), got.last, got.status);
      end
    endfunction

    function int unsigned leftover();
      return expected_rows.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [ACT_W-1:0]        in_action = '0;
  logic [COL_W-1:0]        in_entry_column = '0;
  logic signed [VAL_W-1:0] in_entry_value = '0;
  logic [COL_W-1:0]        in_vector_index = '0;
  logic signed [VAL_W-1:0] in_vector_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [ROW_IDX_W-1:0]    out_row_index;
  logic signed [SUM_W-1:0] out_row_sum;
  logic                    out_last;
  logic [STAT_W-1:0]       out_status;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CNT_W-1:0]        cfg_col_count = COL_COUNT_RESET;

  bit          quiet = 1'b0;
  int unsigned items_sent = 0;
  int unsigned cycles = 0;
  ell_product_scoreboard board = new();

  ell_sparse_matrix_vector_multiply_unit uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_entry_column (in_entry_column),
    .in_entry_value  (in_entry_value),
    .in_vector_index (in_vector_index),
    .in_vector_value (in_vector_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_row_index   (out_row_index),
    .out_row_sum     (out_row_sum),
    .out_last        (out_last),
    .out_status      (out_status),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_col_count   (cfg_col_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL ell_sparse_matrix_vector_multiply_unit");
      $finish;
    end
  end

  function automatic bit idle_roll();
    return !quiet && ($urandom_range(99) < 17);
  endfunction

  always @(negedge clk) begin
    out_stall <= idle_roll();
  end

  always @(posedge clk) begin
    row_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.row_index = out_row_index;
      got.row_sum = out_row_sum;
      got.last = out_last;
      got.status = out_status;
      board.check_result(got);
    end
  end

  function automatic logic [COL_W-1:0] pick_col();
    int unsigned roll = $urandom_range(99);
    if (roll < 50) return COL_W'($urandom_range(15));
    if (roll < 55) return '0;
    if (roll < 60) return '1;
    return COL_W'($urandom);
  endfunction

  function automatic logic [VAL_W-1:0] pick_val();
    int unsigned roll = $urandom_range(99);
    if (roll < 5) return 16'h7fff;
    if (roll < 10) return 16'h8000;
    return VAL_W'($urandom);
  endfunction

  task automatic send_item(input logic [ACT_W-1:0] action, input logic [COL_W-1:0] col,
                           input logic [VAL_W-1:0] val, input logic [COL_W-1:0] vidx,
                           input logic [VAL_W-1:0] vval);
    while (idle_roll()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_action = action;
    in_entry_column = col;
    in_entry_value = val;
    in_vector_index = vidx;
    in_vector_value = vval;
    do @(posedge clk); while (in_stall);
    board.note_transfer(action, col, val, vidx, vval);
    if (action <= ACT_CLEAR) items_sent++;
    @(negedge clk);
  endtask

  task automatic append(input logic [COL_W-1:0] col, input logic [VAL_W-1:0] val);
    send_item(ACT_APPEND, col, val, COL_W'($urandom), VAL_W'($urandom));
  endtask

  task automatic end_row();
    send_item(ACT_END_ROW, COL_W'($urandom), VAL_W'($urandom), COL_W'($urandom),
              VAL_W'($urandom));
  endtask

  task automatic write_vec(input logic [COL_W-1:0] idx, input logic [VAL_W-1:0] val);
    send_item(ACT_WRITE_VEC, COL_W'($urandom), VAL_W'($urandom), idx, val);
  endtask

  task automatic multiply();
    send_item(ACT_MULTIPLY, COL_W'($urandom), VAL_W'($urandom), COL_W'($urandom),
              VAL_W'($urandom));
  endtask

  task automatic clear_matrix();
    send_item(ACT_CLEAR, COL_W'($urandom), VAL_W'($urandom), COL_W'($urandom),
              VAL_W'($urandom));
  endtask

  task automatic send_noise();
    send_item(ACT_W'($urandom), COL_W'($urandom), VAL_W'($urandom), COL_W'($urandom),
              VAL_W'($urandom));
  endtask

  // drop valid, wait for every pending sum, then let trailing work drain
  task automatic settle();
    in_valid = 1'b0;
    while (board.leftover() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_col_count(input logic [CNT_W-1:0] value);
    cfg_valid = 1'b1;
    cfg_col_count = value;
    do @(posedge clk); while (!cfg_ready);
    board.col_count = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_matrix(input int unsigned n_rows, input bit bulky, input bit slot_spill);
    int unsigned len;
    int unsigned roll;
    if (bulky || board.rows_closed > 12 || $urandom_range(99) < 60) clear_matrix();
    for (int unsigned r = 0; r < n_rows; r++) begin
      roll = $urandom_range(99);
      if (slot_spill && r == 0) len = SLOTS + 1;
      else if (bulky && r >= ROWS) len = 1;
      else if (bulky) len = (r % 16 == 5) ? SLOTS : $urandom_range(1);
      else if (roll < 80) len = $urandom_range(5);
      else if (roll < 90) len = SLOTS;
      else len = $urandom_range(SLOTS + 2, SLOTS + 1);
      for (int unsigned k = 0; k < len; k++) begin
        if ($urandom_range(99) < 12) write_vec(pick_col(), pick_val());
        append(pick_col(), pick_val());
      end
      if ($urandom_range(99) < 4) send_noise();
      end_row();
    end
    repeat ($urandom_range(3)) write_vec(pick_col(), pick_val());
    if ($urandom_range(99) < 20) repeat ($urandom_range(2, 1)) append(pick_col(), pick_val());
    multiply();
    if ($urandom_range(99) < 20) multiply();
  endtask

  initial begin
    int unsigned p;
    int unsigned phase_start;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    multiply();
    write_vec(8'd0, 16'h7fff);
    write_vec(8'hff, 16'h8000);
    write_vec(8'd1, 16'h8000);
    append(8'd0, 16'h8000);
    append(8'hff, 16'h7fff);
    append(8'd1, 16'h8000);
    end_row();
    end_row();
    append(8'hff, 16'h8000);
    end_row();
    send_item(3'd5, '1, '1, '1, '1);
    send_item(3'd6, '0, '0, '0, '0);
    send_item(3'd7, '1, '0, '1, '0);
    multiply();
    append(8'd2, 16'h0001);
    multiply();
    clear_matrix();
    multiply();
    write_vec(8'd1, 16'h0100);
    settle();

    p = 0;
    while (p < 8 || items_sent < 450) begin
      write_col_count(COL_SETTINGS[p % 8]);
      quiet = (p == 2);
      phase_start = items_sent;
      repeat (6) write_vec(pick_col(), pick_val());
      if (p == 0) run_matrix(2, 1'b0, 1'b1);
      if (p == 1) run_matrix(ROWS + 2, 1'b1, 1'b0);
      if (p == 4) run_matrix(30, 1'b1, 1'b0);
      while (items_sent - phase_start < 15) run_matrix($urandom_range(6, 1), 1'b0, 1'b0);
      settle();
      p++;
    end
    quiet = 1'b0;
    repeat (20) @(posedge clk);

    if (board.mismatches == 0 && board.leftover() == 0) begin
      $display("PASS ell_sparse_matrix_vector_multiply_unit");
    end else begin
      $display("FAIL ell_sparse_matrix_vector_multiply_unit");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+src
src/ellspmv_pkg.sv
src/ellspmv_ram.sv
src/ell_sparse_matrix_vector_multiply_unit.sv
src/ellspmv_checker.sv
tb/tb.sv
